// ===== rtl/crcfd_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the frame deframer.
`default_nettype none
package crcfd_pkg;

	localparam int HDR_BYTES       = 12;
	localparam int HDR_CNT_W       = 4;
	localparam int HDR_CRC_COVERED = 1 + 1 + 2 + 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC_WORD  = 2'd0,
		CFG_EXP_VERSION = 2'd1,
		CFG_MAX_PAYLOAD = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_HEADER  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		EV_BYTE      = 3'd0,
		EV_OK        = 3'd1,
		EV_CRC_ERR   = 3'd2,
		EV_OVERSIZE  = 3'd3,
		EV_VERSION   = 3'd4
	} event_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  exp_version;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		event_t      ev;
		logic [7:0]  value;
		logic [15:0] index;
		logic [7:0]  flags;
		logic [15:0] command;
		logic [31:0] length;
	} result_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/crcfd_parser.sv =====
// Frame parser: magic hunt, header capture, CRC tracking and verdict per byte.
`default_nettype none
module crcfd_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 fire,
	input  wire  [7:0]          data_byte,
	input  crcfd_pkg::cfg_t     cfg,
	output crcfd_pkg::result_t  res
);
	import crcfd_pkg::*;

	mode_t                mode_q, mode_d;
	logic [31:0]          magic_q, magic_d;
	logic [HDR_CNT_W-1:0] hcnt_q, hcnt_d;
	logic [31:0]          crc_q, crc_d;
	logic [31:0]          pcnt_q, pcnt_d;

	// header store, no reset: always written before it is read
	logic [7:0]  version_q;
	logic [7:0]  flags_q;
	logic [15:0] cmd_q;
	logic [31:0] len_q;
	logic [31:0] crc_exp_q;

	logic [31:0] crc_upd;
	logic [31:0] crc_exp_full;
	logic [31:0] pcnt_inc;
	logic        fits;
	logic        hdr_last;

	assign crc_upd      = crc_byte(crc_q, data_byte);
	assign crc_exp_full = {data_byte, crc_exp_q[23:0]};
	assign pcnt_inc     = pcnt_q + 32'd1;
	assign fits         = len_q <= {16'd0, cfg.max_payload};
	assign hdr_last     = hcnt_q == HDR_CNT_W'(HDR_BYTES - 1);

	always_comb begin
		mode_d        = mode_q;
		magic_d       = magic_q;
		hcnt_d        = hcnt_q;
		crc_d         = crc_q;
		pcnt_d        = pcnt_q;
		res.valid     = 1'b0;
		res.ev        = EV_BYTE;
		res.value     = 8'd0;
		res.index     = 16'd0;
		res.flags     = flags_q;
		res.command   = cmd_q;
		res.length    = len_q;
		case (mode_q)
			MODE_HUNT: begin
				magic_d = {data_byte, magic_q[31:8]};
				if (magic_d == cfg.magic_word) begin
					mode_d = MODE_HEADER;
					hcnt_d = '0;
				end
			end
			MODE_HEADER: begin
				hcnt_d = hcnt_q + HDR_CNT_W'(1);
				if (hcnt_q == '0)
					crc_d = crc_byte(CRC_INIT, data_byte);
				else if (hcnt_q < HDR_CNT_W'(HDR_CRC_COVERED))
					crc_d = crc_upd;
				if (hdr_last) begin
					hcnt_d = '0;
					pcnt_d = '0;
					if (version_q != cfg.exp_version) begin
						mode_d    = MODE_HUNT;
						res.valid = 1'b1;
						res.ev    = EV_VERSION;
					end else if (len_q == 32'd0) begin
						mode_d    = MODE_HUNT;
						magic_d   = '0;
						res.valid = 1'b1;
						res.ev    = ((crc_q ^ CRC_INIT) == crc_exp_full) ? EV_OK : EV_CRC_ERR;
					end else begin
						mode_d = MODE_PAYLOAD;
					end
				end
			end
			MODE_PAYLOAD: begin
				pcnt_d = pcnt_inc;
				crc_d  = crc_upd;
				if (pcnt_inc == len_q) begin
					mode_d    = MODE_HUNT;
					magic_d   = '0;
					res.valid = 1'b1;
					if ((crc_upd ^ CRC_INIT) != crc_exp_q)
						res.ev = EV_CRC_ERR;
					else if (!fits)
						res.ev = EV_OVERSIZE;
					else
						res.ev = EV_OK;
				end else if (fits) begin
					res.valid = 1'b1;
					res.ev    = EV_BYTE;
					res.value = data_byte;
					res.index = pcnt_q[15:0];
				end
			end
			default: begin
				mode_d = MODE_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			magic_q <= '0;
			hcnt_q  <= '0;
			crc_q   <= '0;
			pcnt_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			magic_q <= magic_d;
			hcnt_q  <= hcnt_d;
			crc_q   <= crc_d;
			pcnt_q  <= pcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && mode_q == MODE_HEADER) begin
			case (hcnt_q)
				4'd0:    version_q        <= data_byte;
				4'd1:    flags_q          <= data_byte;
				4'd2:    cmd_q[7:0]       <= data_byte;
				4'd3:    cmd_q[15:8]      <= data_byte;
				4'd4:    len_q[7:0]       <= data_byte;
				4'd5:    len_q[15:8]      <= data_byte;
				4'd6:    len_q[23:16]     <= data_byte;
				4'd7:    len_q[31:24]     <= data_byte;
				4'd8:    crc_exp_q[7:0]   <= data_byte;
				4'd9:    crc_exp_q[15:8]  <= data_byte;
				4'd10:   crc_exp_q[23:16] <= data_byte;
				4'd11:   crc_exp_q[31:24] <= data_byte;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/crc_checked_frame_deframer.sv =====
// Top level of the CRC-checked frame deframer: config registers and pipeline.
//
// Input channel: one received byte per beat (in_valid / in_stall / data_byte).
// Output channel: at most one event per input byte (out_valid / out_stall):
// a payload byte with its index, or a frame verdict (ok, CRC error, oversize,
// version drop), always with the header flags, command and length.
// Config: cfg_we writes cfg_data to register cfg_index (0 magic word,
// 1 expected version, 2 max payload) at a rising edge; write only when idle.
// Pipeline: input register (s1), then one pass of parse and CRC-32 byte update
// into the output register (s2). A result is registered into s2 when its byte
// leaves s1; throughput is one byte per cycle while the receiver does not stall,
// set by the bytewise CRC update and the single parser state register.
// While the receiver stalls, the output register holds its event and one more
// byte may still be taken into the input register; further bytes are stalled.
// Reset clears parser state, the pipeline valids and the config registers to
// magic word 0, version 1, max payload 1024; the block hunts for magic.
`default_nettype none
module crc_checked_frame_deframer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  byte_value,
	output logic [15:0] byte_index,
	output logic [7:0]  frame_flags,
	output logic [15:0] frame_command,
	output logic [31:0] frame_length
);
	import crcfd_pkg::*;

	cfg_t    cfg_q;
	logic    v_s1;
	logic [7:0] byte_s1;
	logic    advance;
	logic    fire;
	result_t res;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word  <= 32'd0;
			cfg_q.exp_version <= 8'd1;
			cfg_q.max_payload <= 16'd1024;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAGIC_WORD:  cfg_q.magic_word  <= cfg_data;
				CFG_EXP_VERSION: cfg_q.exp_version <= cfg_data[7:0];
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign advance  = !res_s2.valid || !out_stall;
	assign in_stall = v_s1 && !advance;
	assign fire     = v_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!in_stall)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= data_byte;
	end

	crcfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			if (advance)
				res_s2.valid <= fire && res.valid;
			if (fire && res.valid) begin
				res_s2.ev      <= res.ev;
				res_s2.value   <= res.value;
				res_s2.index   <= res.index;
				res_s2.flags   <= res.flags;
				res_s2.command <= res.command;
				res_s2.length  <= res.length;
			end
		end
	end

	assign out_valid     = res_s2.valid;
	assign event_res     = res_s2.ev;
	assign byte_value    = res_s2.value;
	assign byte_index    = res_s2.index;
	assign frame_flags   = res_s2.flags;
	assign frame_command = res_s2.command;
	assign frame_length  = res_s2.length;

endmodule
`default_nettype wire
